// ===== rtl/core/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// mie_pkg - shared definitions for the integer execute unit
// Instruction field codes, status codes, stream widths and the structs
// passed between the operand stage and the execute logic.
// ----------------------------------------------------------------------------
package mie_pkg;

   localparam int unsigned XLEN       = 32;
   localparam int unsigned NUM_REGS   = 32;
   localparam int unsigned REG_IDX_W  = 5;
   localparam int unsigned REQ_DATA_W = 96;   // instruction, pc, load_data
   localparam int unsigned RSP_DATA_W = 144;  // 139 bits of fields, zero padded
   localparam int unsigned RSP_USER_W = 2;    // status

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_COP0    = 6'h10;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;

   // SPECIAL function codes
   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_SRA     = 6'h03;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_JALR    = 6'h09;
   localparam logic [5:0] FN_SYSCALL = 6'h0C;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_ADDU    = 6'h21;
   localparam logic [5:0] FN_SUB     = 6'h22;
   localparam logic [5:0] FN_SUBU    = 6'h23;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_XOR     = 6'h26;
   localparam logic [5:0] FN_NOR     = 6'h27;
   localparam logic [5:0] FN_SLT     = 6'h2A;
   localparam logic [5:0] FN_SLTU    = 6'h2B;

   // COP0 sub-ops in the rs field
   localparam logic [4:0] CP0_MF     = 5'd0;
   localparam logic [4:0] CP0_MT     = 5'd4;

   // COP0 register numbers
   localparam logic [4:0] CP0_BPC    = 5'd3;
   localparam logic [4:0] CP0_BDA    = 5'd5;
   localparam logic [4:0] CP0_JDEST  = 5'd6;
   localparam logic [4:0] CP0_DCIC   = 5'd7;
   localparam logic [4:0] CP0_BDAM   = 5'd9;
   localparam logic [4:0] CP0_BPCM   = 5'd11;
   localparam logic [4:0] CP0_SR     = 5'd12;
   localparam logic [4:0] CP0_CAUSE  = 5'd13;

   localparam logic [4:0] REG_LINK   = 5'd31;
   localparam int unsigned SR_ISOLATE = 16;
   localparam logic [31:0] PC_REGION_MASK = 32'hF000_0000;

   // access sizes
   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_HALF  = 2'd1;
   localparam logic [1:0] SIZE_WORD  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_NORMAL  = 2'd0;
   localparam logic [1:0] ST_SYSCALL = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   typedef struct packed {
      logic                 branch_taken;
      logic [XLEN-1:0]      branch_target;
      logic                 mem_read;
      logic                 mem_write;
      logic [1:0]           mem_size;
      logic [XLEN-1:0]      mem_address;
      logic [XLEN-1:0]      mem_store_data;
      logic                 reg_write;
      logic [REG_IDX_W-1:0] reg_index;
      logic [XLEN-1:0]      reg_value;
      logic [1:0]           status;
   } result_type;

   // state updates requested by one item
   typedef struct packed {
      logic            sr_we;
      logic            cause_we;
      logic [XLEN-1:0] cp0_value;
   } cp0_wr_type;

endpackage

// ===== rtl/core/mie_ram.sv =====
// ----------------------------------------------------------------------------
// mie_ram - generic RAM, one write port, two registered read ports
// Read data updates only on a read enable and holds otherwise.
// ----------------------------------------------------------------------------
module mie_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/core/mie_exec.sv =====
// ----------------------------------------------------------------------------
// mie_exec - instruction decode and execute
// Pure combinational: decodes one instruction with its operands and gives
// the result item plus any COP0 register update.
// ----------------------------------------------------------------------------
module mie_exec
   import mie_pkg::*;
(
   input  logic [XLEN-1:0] instruction,
   input  logic [XLEN-1:0] pc,
   input  logic [XLEN-1:0] load_data,
   input  logic [XLEN-1:0] rs_value,
   input  logic [XLEN-1:0] rt_value,
   input  logic [XLEN-1:0] cop0_status,
   output result_type      result,
   output cp0_wr_type      cp0_wr
);

   logic [5:0]           op;
   logic [5:0]           fn;
   logic [REG_IDX_W-1:0] rs;
   logic [REG_IDX_W-1:0] rt;
   logic [REG_IDX_W-1:0] rd;
   logic [4:0]           sh;
   logic [15:0]          imm;
   logic [XLEN-1:0]      simm;
   logic [XLEN-1:0]      pc4;
   logic [XLEN-1:0]      pc8;
   logic [XLEN-1:0]      btarget;
   logic [XLEN-1:0]      addr;
   logic                 isolated;
   result_type           r;

   assign op       = instruction[31:26];
   assign rs       = instruction[25:21];
   assign rt       = instruction[20:16];
   assign rd       = instruction[15:11];
   assign sh       = instruction[10:6];
   assign fn       = instruction[5:0];
   assign imm      = instruction[15:0];
   assign simm     = {{16{imm[15]}}, imm};
   assign pc4      = pc + 32'd4;
   assign pc8      = pc + 32'd8;
   assign btarget  = pc4 + {simm[29:0], 2'b00};
   assign addr     = rs_value + simm;
   assign isolated = cop0_status[SR_ISOLATE];

   always_comb begin
      r      = '0;
      cp0_wr = '0;
      cp0_wr.cp0_value = rt_value;
      case (op)
         OP_SPECIAL: begin
            r.reg_write = 1'b1;
            r.reg_index = rd;
            case (fn)
               FN_SLL:  r.reg_value = rt_value << sh;
               FN_SRL:  r.reg_value = rt_value >> sh;
               FN_SRA:  r.reg_value = $unsigned($signed(rt_value) >>> sh);
               FN_JR: begin
                  r.reg_write     = 1'b0;
                  r.branch_taken  = 1'b1;
                  r.branch_target = rs_value;
               end
               FN_JALR: begin
                  r.reg_value     = pc8;
                  r.branch_taken  = 1'b1;
                  r.branch_target = rs_value;
               end
               FN_SYSCALL: begin
                  r.reg_write = 1'b0;
                  r.status    = ST_SYSCALL;
               end
               FN_ADD, FN_ADDU: r.reg_value = rs_value + rt_value;
               FN_SUB, FN_SUBU: r.reg_value = rs_value - rt_value;
               FN_AND:  r.reg_value = rs_value & rt_value;
               FN_OR:   r.reg_value = rs_value | rt_value;
               FN_XOR:  r.reg_value = rs_value ^ rt_value;
               FN_NOR:  r.reg_value = ~(rs_value | rt_value);
               FN_SLT:  r.reg_value = {31'd0, $signed(rs_value) < $signed(rt_value)};
               FN_SLTU: r.reg_value = {31'd0, rs_value < rt_value};
               default: begin
                  r.reg_write = 1'b0;
                  r.status    = ST_INVALID;
               end
            endcase
         end
         OP_J, OP_JAL: begin
            r.branch_taken  = 1'b1;
            r.branch_target = (pc4 & PC_REGION_MASK) | {4'd0, instruction[25:0], 2'b00};
            if (op == OP_JAL) begin
               r.reg_write = 1'b1;
               r.reg_index = REG_LINK;
               r.reg_value = pc8;
            end
         end
         OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
            case (op)
               OP_BEQ:  r.branch_taken = (rs_value == rt_value);
               OP_BNE:  r.branch_taken = (rs_value != rt_value);
               OP_BLEZ: r.branch_taken = (rs_value == '0) || rs_value[XLEN-1];
               default: r.branch_taken = (rs_value != '0) && !rs_value[XLEN-1];
            endcase
            r.branch_target = btarget;
         end
         OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
            r.reg_write = 1'b1;
            r.reg_index = rt;
            case (op)
               OP_SLTI:  r.reg_value = {31'd0, $signed(rs_value) < $signed(simm)};
               OP_SLTIU: r.reg_value = {31'd0, rs_value < simm};
               OP_ANDI:  r.reg_value = rs_value & {16'd0, imm};
               OP_ORI:   r.reg_value = rs_value | {16'd0, imm};
               OP_XORI:  r.reg_value = rs_value ^ {16'd0, imm};
               OP_LUI:   r.reg_value = {imm, 16'd0};
               default:  r.reg_value = rs_value + simm;
            endcase
         end
         OP_COP0: begin
            if (rs == CP0_MF && rd == CP0_SR) begin
               r.reg_write = 1'b1;
               r.reg_index = rt;
               r.reg_value = cop0_status;
            end else if (rs == CP0_MT) begin
               case (rd) inside
                  CP0_BPC, CP0_BDA, CP0_JDEST, CP0_DCIC, CP0_BDAM, CP0_BPCM: begin
                     // breakpoint registers are not kept; only rt zero is harmless
                     if (rt != '0) begin
                        r.status = ST_INVALID;
                     end
                  end
                  CP0_SR:    cp0_wr.sr_we    = 1'b1;
                  CP0_CAUSE: cp0_wr.cause_we = 1'b1;
                  default:   r.status        = ST_INVALID;
               endcase
            end else begin
               r.status = ST_INVALID;
            end
         end
         OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
            // isolated cache: the register still gets written, with zero
            r.reg_write = 1'b1;
            r.reg_index = rt;
            if (!isolated) begin
               r.mem_read    = 1'b1;
               r.mem_address = addr;
               case (op)
                  OP_LB: begin
                     r.mem_size  = SIZE_BYTE;
                     r.reg_value = {{24{load_data[7]}}, load_data[7:0]};
                  end
                  OP_LBU: begin
                     r.mem_size  = SIZE_BYTE;
                     r.reg_value = {24'd0, load_data[7:0]};
                  end
                  OP_LH: begin
                     r.mem_size  = SIZE_HALF;
                     r.reg_value = {{16{load_data[15]}}, load_data[15:0]};
                  end
                  OP_LHU: begin
                     r.mem_size  = SIZE_HALF;
                     r.reg_value = {16'd0, load_data[15:0]};
                  end
                  default: begin
                     r.mem_size  = SIZE_WORD;
                     r.reg_value = load_data;
                  end
               endcase
            end
         end
         OP_SB, OP_SH, OP_SW: begin
            if (!isolated) begin
               r.mem_write   = 1'b1;
               r.mem_address = addr;
               case (op)
                  OP_SB: begin
                     r.mem_size       = SIZE_BYTE;
                     r.mem_store_data = {24'd0, rt_value[7:0]};
                  end
                  OP_SH: begin
                     r.mem_size       = SIZE_HALF;
                     r.mem_store_data = {16'd0, rt_value[15:0]};
                  end
                  default: begin
                     r.mem_size       = SIZE_WORD;
                     r.mem_store_data = rt_value;
                  end
               endcase
            end
         end
         default: r.status = ST_INVALID;
      endcase

      // writes to register zero vanish
      if (!r.reg_write || r.reg_index == '0) begin
         r.reg_write = 1'b0;
         r.reg_index = '0;
         r.reg_value = '0;
      end
      if (!r.branch_taken) begin
         r.branch_target = '0;
      end
      result = r;
   end

endmodule

// ===== rtl/core/mips_integer_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mips_integer_execute_unit - MIPS I integer execute unit
// Result path: an accepted instruction is read from the register file and
// captured in stage 1 on the accept edge, then executed into the result
// register once stage 1 moves on.
// Throughput: one item per cycle while rsp_tready does not hold the result.
// Reset: synchronous; register file valid bits, COP0 registers and all
// handshake state clear at once, so every register reads as zero.
// ----------------------------------------------------------------------------
//
// Pipeline
//   accept : rs/rt indices from the incoming item address the register file
//            RAM; instruction, pc and load_data are captured in stage 1.
//   stage 1: operands come from the RAM, a one-entry bypass of the most
//            recent write (covers a write landing on the same edge as the
//            read) and per-register valid bits (unwritten reads as zero).
//            The execute logic runs and, when stage 1 moves on, the register
//            file and COP0 are updated and the result register is loaded.
//   result : held until rsp_tready; stage 1 may refill behind it.
//
module mips_integer_execute_unit
   import mie_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] instruction, [63:32] pc, [95:64] load_data
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] branch_taken, [32:1] branch_target, [33] mem_read, [34] mem_write,
   // [36:35] mem_size, [68:37] mem_address, [100:69] mem_store_data,
   // [101] reg_write, [106:102] reg_index, [138:107] reg_value, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int unsigned FIELDS_W = $bits(result_type) - 2;

   logic                 req_accept;
   logic                 advance;

   // stage 1
   logic                 s1_valid_ff, s1_valid_in;
   logic [XLEN-1:0]      s1_ins_ff;
   logic [XLEN-1:0]      s1_pc_ff;
   logic [XLEN-1:0]      s1_ld_ff;

   // register file support
   logic [NUM_REGS-1:0]  rf_valid_ff, rf_valid_in;
   logic                 byp_valid_ff, byp_valid_in;
   logic [REG_IDX_W-1:0] byp_idx_ff;
   logic [XLEN-1:0]      byp_val_ff;
   logic [XLEN-1:0]      ram_rs;
   logic [XLEN-1:0]      ram_rt;
   logic [XLEN-1:0]      rs_value;
   logic [XLEN-1:0]      rt_value;
   logic                 rf_we;

   // COP0
   logic [XLEN-1:0]      cop0_status_ff;
   logic [XLEN-1:0]      cop0_cause_ff;

   // execute and result
   result_type           exec_result;
   cp0_wr_type           exec_cp0;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   // ---- handshake -----------------------------------------------------------
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // ---- register file -------------------------------------------------------
   assign rf_we = advance && exec_result.reg_write;

   mie_ram #(
      .WIDTH (XLEN),
      .DEPTH (NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (rf_we),
      .wr_addr   (exec_result.reg_index),
      .wr_data   (exec_result.reg_value),
      .rd_en     (req_accept),
      .rd_addr_a (req_tdata[25:21]),
      .rd_addr_b (req_tdata[20:16]),
      .rd_data_a (ram_rs),
      .rd_data_b (ram_rt)
   );

   always_comb begin
      rf_valid_in = rf_valid_ff;
      if (rf_we) begin
         rf_valid_in[exec_result.reg_index] = 1'b1;
      end
   end
   assign byp_valid_in = byp_valid_ff || rf_we;

   // operand select: r0, latest write, stored value, never written
   function automatic logic [XLEN-1:0] operand(
      input logic [REG_IDX_W-1:0] idx,
      input logic [XLEN-1:0]      ram_val,
      input logic [NUM_REGS-1:0]  valid,
      input logic                 bv,
      input logic [REG_IDX_W-1:0] bidx,
      input logic [XLEN-1:0]      bval
   );
      logic [XLEN-1:0] v;
      if (idx == '0) begin
         v = '0;
      end else if (bv && bidx == idx) begin
         v = bval;
      end else if (valid[idx]) begin
         v = ram_val;
      end else begin
         v = '0;
      end
      return v;
   endfunction

   assign rs_value = operand(s1_ins_ff[25:21], ram_rs, rf_valid_ff,
                             byp_valid_ff, byp_idx_ff, byp_val_ff);
   assign rt_value = operand(s1_ins_ff[20:16], ram_rt, rf_valid_ff,
                             byp_valid_ff, byp_idx_ff, byp_val_ff);

   // ---- execute -------------------------------------------------------------
   mie_exec u_exec (
      .instruction (s1_ins_ff),
      .pc          (s1_pc_ff),
      .load_data   (s1_ld_ff),
      .rs_value    (rs_value),
      .rt_value    (rt_value),
      .cop0_status (cop0_status_ff),
      .result      (exec_result),
      .cp0_wr      (exec_cp0)
   );

   // ---- control registers ---------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rf_valid_ff    <= '0;
         byp_valid_ff   <= 1'b0;
         cop0_status_ff <= '0;
         cop0_cause_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rf_valid_ff  <= rf_valid_in;
         byp_valid_ff <= byp_valid_in;
         if (advance && exec_cp0.sr_we) begin
            cop0_status_ff <= exec_cp0.cp0_value;
         end
         if (advance && exec_cp0.cause_we) begin
            cop0_cause_ff <= exec_cp0.cp0_value;
         end
      end
   end

   // ---- payload registers ---------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ins_ff <= req_tdata[31:0];
         s1_pc_ff  <= req_tdata[63:32];
         s1_ld_ff  <= req_tdata[95:64];
      end
      if (rf_we) begin
         byp_idx_ff <= exec_result.reg_index;
         byp_val_ff <= exec_result.reg_value;
      end
      if (advance) begin
         rsp_data_ff <= {{(RSP_DATA_W - FIELDS_W){1'b0}},
                         exec_result.reg_value,
                         exec_result.reg_index,
                         exec_result.reg_write,
                         exec_result.mem_store_data,
                         exec_result.mem_address,
                         exec_result.mem_size,
                         exec_result.mem_write,
                         exec_result.mem_read,
                         exec_result.branch_target,
                         exec_result.branch_taken};
         rsp_user_ff <= exec_result.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== tb/tb_mips_integer_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mips_integer_execute_unit - regression bench for the integer execute unit
// Feeds instruction items (directed corner cases, then constrained-random
// instruction mixes) through the request stream. An in-bench model of the
// register file and COP0 state predicts every result item, which is then
// compared field by field with what the block returns. Sender gaps and
// receiver stalls vary by phase, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_mips_integer_execute_unit
   import mie_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned ITEMS_PER_PHASE = 412;
   localparam int unsigned HOLD_CYCLES     = 200;
   localparam int unsigned REPORT_LIMIT    = 10;
   localparam int unsigned DRAIN_CYCLES    = 8;

   // encodings the block must reject
   localparam logic [5:0] OP_REGIMM    = 6'h01;
   localparam logic [5:0] OP_UNUSED    = 6'h3F;
   localparam logic [5:0] FN_UNUSED    = 6'h3F;
   localparam logic [4:0] CP0_CF       = 5'd2;    // COP0 sub-op outside MF/MT

   // -------------------------------------------------------------------------
   // Scoreboard: holds its own copy of the GPRs and COP0 SR/CAUSE, predicts
   // each accepted item and checks returned items in order.
   // -------------------------------------------------------------------------
   class exec_scoreboard;
      logic [XLEN-1:0] gpr [NUM_REGS];
      logic [XLEN-1:0] sr;
      logic [XLEN-1:0] cause;
      result_type      pending_results [$];
      int unsigned     mismatch_count;

      function new();
         foreach (gpr[i]) gpr[i] = '0;
         sr             = '0;
         cause          = '0;
         mismatch_count = 0;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      // executes one instruction against the shadow state
      function result_type execute_instruction(logic [31:0] ins, logic [31:0] pc,
                                               logic [31:0] ld);
         result_type  r;
         logic [5:0]  op, fn;
         logic [4:0]  rs, rt, rd, sa, widx;
         logic [15:0] imm;
         logic [31:0] simm, vs, vt, addr, wval, pc_next, btgt;
         logic        wr, isolated, cond_branch;
         r           = '0;
         wr          = 1'b0;
         widx        = '0;
         wval        = '0;
         cond_branch = 1'b0;
         op          = ins[31:26];
         rs          = ins[25:21];
         rt          = ins[20:16];
         rd          = ins[15:11];
         sa          = ins[10:6];
         fn          = ins[5:0];
         imm         = ins[15:0];
         simm        = {{16{imm[15]}}, imm};
         vs          = gpr[rs];            // gpr[0] is never written, reads zero
         vt          = gpr[rt];
         addr        = vs + simm;
         pc_next     = pc + 32'd4;
         btgt        = pc_next + (simm << 2);
         isolated    = sr[SR_ISOLATE];

         case (op)
            OP_SPECIAL: begin
               wr   = 1'b1;
               widx = rd;
               case (fn)
                  FN_SLL: wval = vt << sa;
                  FN_SRL: wval = vt >> sa;
                  FN_SRA: wval = $signed(vt) >>> sa;
                  FN_JR: begin
                     wr              = 1'b0;
                     r.branch_taken  = 1'b1;
                     r.branch_target = vs;
                  end
                  FN_JALR: begin
                     wval            = pc + 32'd8;
                     r.branch_taken  = 1'b1;
                     r.branch_target = vs;
                  end
                  FN_SYSCALL: begin
                     wr       = 1'b0;
                     r.status = ST_SYSCALL;
                  end
                  FN_ADD, FN_ADDU: wval = vs + vt;   // wraps, no overflow trap
                  FN_SUB, FN_SUBU: wval = vs - vt;
                  FN_AND:  wval = vs & vt;
                  FN_OR:   wval = vs | vt;
                  FN_XOR:  wval = vs ^ vt;
                  FN_NOR:  wval = ~(vs | vt);
                  FN_SLT:  wval = {31'b0, $signed(vs) < $signed(vt)};
                  FN_SLTU: wval = {31'b0, vs < vt};
                  default: begin
                     wr       = 1'b0;
                     r.status = ST_INVALID;
                  end
               endcase
            end
            OP_J, OP_JAL: begin
               r.branch_taken  = 1'b1;
               r.branch_target = (pc_next & PC_REGION_MASK) | {4'b0, ins[25:0], 2'b00};
               if (op == OP_JAL) begin
                  wr   = 1'b1;
                  widx = REG_LINK;
                  wval = pc + 32'd8;
               end
            end
            OP_BEQ: begin
               cond_branch    = 1'b1;
               r.branch_taken = (vs == vt);
            end
            OP_BNE: begin
               cond_branch    = 1'b1;
               r.branch_taken = (vs != vt);
            end
            OP_BLEZ: begin
               cond_branch    = 1'b1;
               r.branch_taken = (vs == '0) || vs[31];
            end
            OP_BGTZ: begin
               cond_branch    = 1'b1;
               r.branch_taken = (vs != '0) && !vs[31];
            end
            OP_ADDI, OP_ADDIU: begin
               wr   = 1'b1;
               widx = rt;
               wval = vs + simm;
            end
            OP_SLTI: begin
               wr   = 1'b1;
               widx = rt;
               wval = {31'b0, $signed(vs) < $signed(simm)};
            end
            OP_SLTIU: begin
               wr   = 1'b1;
               widx = rt;
               wval = {31'b0, vs < simm};
            end
            OP_ANDI: begin
               wr   = 1'b1;
               widx = rt;
               wval = vs & {16'b0, imm};
            end
            OP_ORI: begin
               wr   = 1'b1;
               widx = rt;
               wval = vs | {16'b0, imm};
            end
            OP_XORI: begin
               wr   = 1'b1;
               widx = rt;
               wval = vs ^ {16'b0, imm};
            end
            OP_LUI: begin
               wr   = 1'b1;
               widx = rt;
               wval = {imm, 16'b0};
            end
            OP_COP0: begin
               if (rs == CP0_MF && rd == CP0_SR) begin
                  wr   = 1'b1;
                  widx = rt;
                  wval = sr;
               end else if (rs == CP0_MT) begin
                  case (rd)
                     // breakpoint registers: only a write of r0 is tolerated
                     CP0_BPC, CP0_BDA, CP0_JDEST, CP0_DCIC, CP0_BDAM, CP0_BPCM:
                        if (rt != '0) r.status = ST_INVALID;
                     CP0_SR:    sr    = vt;
                     CP0_CAUSE: cause = vt;
                     default:   r.status = ST_INVALID;
                  endcase
               end else begin
                  r.status = ST_INVALID;
               end
            end
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
               // isolated cache: register still written, with zero
               wr   = 1'b1;
               widx = rt;
               wval = '0;
               if (!isolated) begin
                  r.mem_read    = 1'b1;
                  r.mem_address = addr;
                  case (op)
                     OP_LB: begin
                        r.mem_size = SIZE_BYTE;
                        wval       = {{24{ld[7]}}, ld[7:0]};
                     end
                     OP_LBU: begin
                        r.mem_size = SIZE_BYTE;
                        wval       = {24'b0, ld[7:0]};
                     end
                     OP_LH: begin
                        r.mem_size = SIZE_HALF;
                        wval       = {{16{ld[15]}}, ld[15:0]};
                     end
                     OP_LHU: begin
                        r.mem_size = SIZE_HALF;
                        wval       = {16'b0, ld[15:0]};
                     end
                     default: begin
                        r.mem_size = SIZE_WORD;
                        wval       = ld;
                     end
                  endcase
               end
            end
            OP_SB, OP_SH, OP_SW: begin
               if (!isolated) begin
                  r.mem_write   = 1'b1;
                  r.mem_address = addr;
                  case (op)
                     OP_SB: begin
                        r.mem_size       = SIZE_BYTE;
                        r.mem_store_data = {24'b0, vt[7:0]};
                     end
                     OP_SH: begin
                        r.mem_size       = SIZE_HALF;
                        r.mem_store_data = {16'b0, vt[15:0]};
                     end
                     default: begin
                        r.mem_size       = SIZE_WORD;
                        r.mem_store_data = vt;
                     end
                  endcase
               end
            end
            default: r.status = ST_INVALID;
         endcase

         if (cond_branch && r.branch_taken) r.branch_target = btgt;
         // writes to r0 vanish, and so do the register fields
         if (wr && widx != '0) begin
            gpr[widx]   = wval;
            r.reg_write = 1'b1;
            r.reg_index = widx;
            r.reg_value = wval;
         end
         return r;
      endfunction

      function void note_item(logic [31:0] ins, logic [31:0] pc, logic [31:0] ld);
         pending_results.push_back(execute_instruction(ins, pc, ld));
      endfunction

      function void flag(string what, logic [31:0] exp_val, logic [31:0] got_val);
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t mismatch on %s: expected %h, got %h",
                     $realtime, what, exp_val, got_val);
      endfunction

      function void check_result(result_type got);
         result_type exp;
         if (pending_results.size() == 0) begin
            flag("item with none pending (reg_value)", '0, got.reg_value);
            return;
         end
         exp = pending_results.pop_front();
         if (got.branch_taken !== exp.branch_taken)
            flag("branch_taken", 32'(exp.branch_taken), 32'(got.branch_taken));
         if (got.branch_target !== exp.branch_target)
            flag("branch_target", exp.branch_target, got.branch_target);
         if (got.mem_read !== exp.mem_read)
            flag("mem_read", 32'(exp.mem_read), 32'(got.mem_read));
         if (got.mem_write !== exp.mem_write)
            flag("mem_write", 32'(exp.mem_write), 32'(got.mem_write));
         if (got.mem_size !== exp.mem_size)
            flag("mem_size", 32'(exp.mem_size), 32'(got.mem_size));
         if (got.mem_address !== exp.mem_address)
            flag("mem_address", exp.mem_address, got.mem_address);
         if (got.mem_store_data !== exp.mem_store_data)
            flag("mem_store_data", exp.mem_store_data, got.mem_store_data);
         if (got.reg_write !== exp.reg_write)
            flag("reg_write", 32'(exp.reg_write), 32'(got.reg_write));
         if (got.reg_index !== exp.reg_index)
            flag("reg_index", 32'(exp.reg_index), 32'(got.reg_index));
         if (got.reg_value !== exp.reg_value)
            flag("reg_value", exp.reg_value, got.reg_value);
         if (got.status !== exp.status)
            flag("status", 32'(exp.status), 32'(got.status));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block under test
   // -------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   exec_scoreboard results_board;
   int unsigned    sender_idle_pct    = 0;
   int unsigned    receiver_stall_pct = 0;
   bit             hold_request       = 1'b0;   // raised by the stimulus, cleared below
   int unsigned    hold_left          = 0;
   int unsigned    cycle_count        = 0;

   mips_integer_execute_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mips_integer_execute_unit regression: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Instruction encoding and random picks
   // -------------------------------------------------------------------------
   function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sa);
      return {OP_SPECIAL, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] index);
      return {op, index};
   endfunction

   function automatic logic [31:0] enc_cop0(logic [4:0] sub, logic [4:0] rt, logic [4:0] rd);
      return {OP_COP0, sub, rt, rd, 11'b0};
   endfunction

   // word with its extremes over-represented
   function automatic logic [31:0] edgy_word();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // mostly a small pool of registers, so results feed later operands
   function automatic logic [4:0] pick_reg();
      if ($urandom_range(3) != 0) return 5'($urandom_range(7));
      return 5'($urandom_range(31));
   endfunction

   function automatic logic [31:0] random_instruction();
      logic [31:0] w;
      logic [15:0] imm;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sa;
      int unsigned pick;
      w    = edgy_word();
      imm  = w[31:16];
      rs   = pick_reg();
      rt   = pick_reg();
      rd   = pick_reg();
      sa   = 5'($urandom_range(31));
      op   = OP_SPECIAL;
      pick = $urandom_range(99);
      if (pick < 5) return $urandom();      // raw noise, mostly rejected encodings
      if (pick < 35) begin
         case ($urandom_range(16))
            0:       fn = FN_SLL;
            1:       fn = FN_SRL;
            2:       fn = FN_SRA;
            3:       fn = FN_JR;
            4:       fn = FN_JALR;
            5:       fn = FN_SYSCALL;
            6:       fn = FN_ADD;
            7:       fn = FN_ADDU;
            8:       fn = FN_SUB;
            9:       fn = FN_SUBU;
            10:      fn = FN_AND;
            11:      fn = FN_OR;
            12:      fn = FN_XOR;
            13:      fn = FN_NOR;
            14:      fn = FN_SLT;
            15:      fn = FN_SLTU;
            default: fn = 6'($urandom_range(63));
         endcase
         return enc_r(fn, rs, rt, rd, sa);
      end
      if (pick < 92) begin
         if (pick < 45) begin
            case ($urandom_range(5))
               0:       op = OP_J;
               1:       op = OP_JAL;
               2:       op = OP_BEQ;
               3:       op = OP_BNE;
               4:       op = OP_BLEZ;
               default: op = OP_BGTZ;
            endcase
         end else if (pick < 70) begin
            case ($urandom_range(7))
               0:       op = OP_ADDI;
               1:       op = OP_ADDIU;
               2:       op = OP_SLTI;
               3:       op = OP_SLTIU;
               4:       op = OP_ANDI;
               5:       op = OP_ORI;
               6:       op = OP_XORI;
               default: op = OP_LUI;
            endcase
         end else if (pick < 82) begin
            case ($urandom_range(4))
               0:       op = OP_LB;
               1:       op = OP_LH;
               2:       op = OP_LW;
               3:       op = OP_LBU;
               default: op = OP_LHU;
            endcase
         end else begin
            case ($urandom_range(2))
               0:       op = OP_SB;
               1:       op = OP_SH;
               default: op = OP_SW;
            endcase
         end
         if (op == OP_J || op == OP_JAL) return enc_j(op, {rs, rt, imm});
         return enc_i(op, rs, rt, imm);
      end
      // COP0: mostly legal moves; SR writes usually from r0 so isolation
      // comes and goes rather than sticking
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            rs = CP0_MF;
            rd = CP0_SR;
         end
         4, 5: begin
            rs = CP0_MT;
            rd = CP0_SR;
            if ($urandom_range(2) != 0) rt = '0;
         end
         6: begin
            rs = CP0_MT;
            rd = CP0_CAUSE;
         end
         7: begin
            rs = CP0_MT;
            case ($urandom_range(5))
               0:       rd = CP0_BPC;
               1:       rd = CP0_BDA;
               2:       rd = CP0_JDEST;
               3:       rd = CP0_DCIC;
               4:       rd = CP0_BDAM;
               default: rd = CP0_BPCM;
            endcase
            if ($urandom_range(1) != 0) rt = '0;
         end
         8: begin
            rs = CP0_MT;
            rd = 5'($urandom_range(31));
         end
         default: begin
            rs = 5'($urandom_range(31));
            rd = 5'($urandom_range(31));
         end
      endcase
      return {OP_COP0, rs, rt, rd, w[10:0]};
   endfunction

   // -------------------------------------------------------------------------
   // Request side: optional idle cycles, then hold the item until accepted.
   // tvalid stays high into the next call so back-to-back items need no gap.
   // -------------------------------------------------------------------------
   task automatic offer_item(input logic [31:0] ins, input logic [31:0] pc,
                             input logic [31:0] ld);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ld, pc, ins};
      do @(posedge clock); while (!req_tready);
      results_board.note_item(ins, pc, ld);
   endtask

   // sender goes quiet until every predicted item has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (results_board.pending() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Result side: check on each handshake, then choose the next tready.
   // A hold-off request turns into a long stretch with tready low.
   // -------------------------------------------------------------------------
   initial begin
      result_type got;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.branch_taken   = rsp_tdata[0];
            got.branch_target  = rsp_tdata[32:1];
            got.mem_read       = rsp_tdata[33];
            got.mem_write      = rsp_tdata[34];
            got.mem_size       = rsp_tdata[36:35];
            got.mem_address    = rsp_tdata[68:37];
            got.mem_store_data = rsp_tdata[100:69];
            got.reg_write      = rsp_tdata[101];
            got.reg_index      = rsp_tdata[106:102];
            got.reg_value      = rsp_tdata[138:107];
            got.status         = rsp_tuser[1:0];
            results_board.check_result(got);
         end
         if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_tready   <= 1'b0;
         end else begin
            rsp_tready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned phase;
      int unsigned n;
      results_board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: wrap-around arithmetic, r0 writes, branch edge cases,
      // load extension, rejected encodings, COP0 moves and cache isolation
      offer_item(enc_i(OP_LUI, 5'd0, 5'd1, 16'hFFFF), 32'h0040_0000, '0);
      offer_item(enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF), 32'h0040_0004, '1);
      offer_item(enc_i(OP_LUI, 5'd0, 5'd2, 16'h8000), 32'h0040_0008, '0);
      offer_item(enc_i(OP_ADDI, 5'd2, 5'd3, 16'hFFFF), 32'h0040_000C, '0);  // wraps
      offer_item(enc_r(FN_ADD, 5'd3, 5'd3, 5'd4, 5'd0), 32'h0040_0010, '0);  // wraps
      offer_item(enc_r(FN_SUB, 5'd2, 5'd3, 5'd5, 5'd0), 32'h0040_0014, '0);  // wraps
      offer_item(enc_i(OP_ADDIU, 5'd1, 5'd0, 16'h0005), 32'h0040_0018, '0); // r0 target
      offer_item(enc_r(FN_SLT, 5'd2, 5'd3, 5'd6, 5'd0), 32'h0040_001C, '0);
      offer_item(enc_r(FN_SRA, 5'd0, 5'd2, 5'd7, 5'd31), 32'h0040_0020, '0);
      offer_item(enc_i(OP_BEQ, 5'd1, 5'd2, 16'hFFFF), 32'h0040_0024, '0);   // not taken
      offer_item(enc_i(OP_BNE, 5'd1, 5'd2, 16'h8000), 32'h0000_0000, '0);
      offer_item(enc_i(OP_BLEZ, 5'd2, 5'd0, 16'h7FFF), 32'hFFFF_FFFC, '0);
      offer_item(enc_j(OP_JAL, '1), 32'hFFFF_FFFC, '0);                     // pc+4 wraps
      offer_item(enc_r(FN_JALR, 5'd1, 5'd0, 5'd9, 5'd0), 32'h7FFF_FFFC, '0);
      offer_item(enc_i(OP_LW, 5'd1, 5'd10, 16'h8000), 32'h0040_0028, '1);
      offer_item(enc_i(OP_LB, 5'd0, 5'd11, 16'h7FFF), 32'h0040_002C, 32'h0000_0080);
      offer_item(enc_i(OP_SH, 5'd2, 5'd1, 16'hFFFF), 32'h0040_0030, '0);
      offer_item(enc_r(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0), 32'h0040_0034, '0);
      offer_item(enc_j(OP_UNUSED, '1), 32'h0040_0038, '0);
      offer_item(enc_r(FN_UNUSED, 5'd1, 5'd2, 5'd3, 5'd0), 32'h0040_003C, '0);
      offer_item(enc_i(OP_REGIMM, 5'd1, 5'd0, 16'h0000), 32'h0040_0040, '0);
      offer_item(enc_cop0(CP0_CF, 5'd1, CP0_SR), 32'h0040_0044, '0);
      offer_item(enc_cop0(CP0_MF, 5'd1, CP0_CAUSE), 32'h0040_0048, '0);   // only SR readable
      offer_item(enc_cop0(CP0_MT, 5'd5, CP0_BPC), 32'h0040_004C, '0);     // rejected
      offer_item(enc_cop0(CP0_MT, 5'd0, CP0_DCIC), 32'h0040_0050, '0);    // ignored
      offer_item(enc_cop0(CP0_MT, 5'd1, CP0_CAUSE), 32'h0040_0054, '0);
      offer_item(enc_cop0(CP0_MT, 5'd1, CP0_SR), 32'h0040_0058, '0);      // isolate on
      offer_item(enc_cop0(CP0_MF, 5'd12, CP0_SR), 32'h0040_005C, '0);
      offer_item(enc_i(OP_LBU, 5'd1, 5'd13, 16'h0000), 32'h0040_0060, '1);
      offer_item(enc_i(OP_SW, 5'd1, 5'd1, 16'h0000), 32'h0040_0064, '0);
      offer_item(enc_cop0(CP0_MT, 5'd0, CP0_SR), 32'h0040_0068, '0);      // isolate off
      wait_results_drained();

      // random phases: free running, sender gaps, receiver stalls, both
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 48;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 48;
            end
            default: begin
               sender_idle_pct    = 38;
               receiver_stall_pct = 38;
            end
         endcase
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // mid-way through the free-running phase the receiver backs off
            // while items keep coming, so the pipe fills and req_tready drops
            if (phase == 0 && n == ITEMS_PER_PHASE / 2) hold_request = 1'b1;
            offer_item(random_instruction(), edgy_word(), edgy_word());
         end
         wait_results_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (results_board.mismatch_count == 0 && results_board.pending() == 0) begin
         $display("mips_integer_execute_unit regression: pass");
      end else begin
         $display("mips_integer_execute_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/mie_pkg.sv
rtl/core/mie_ram.sv
rtl/core/mie_exec.sv
rtl/core/mips_integer_execute_unit.sv
tb/tb_mips_integer_execute_unit.sv
